### rtl/gcf_pkg.sv
// gcf_pkg: shared constants, register codes and types for the gradient contour filter
// no dependencies; used by the interfaces, the line store, the top level and the checker
package gcf_pkg;

    localparam int MAX_WIDTH     = 512;
    localparam int ROW_LIMIT     = 512;
    localparam int PIXEL_BITS    = 16;
    localparam int GRAY_BITS     = 16;
    localparam int SIZE_BITS     = 10;
    localparam int COL_BITS      = $clog2(MAX_WIDTH);
    localparam int ROW_BITS      = $clog2(ROW_LIMIT);
    localparam int CFG_IDX_BITS  = 2;
    localparam int CFG_DATA_BITS = 16;

    typedef enum logic [CFG_IDX_BITS-1:0] {
        CFG_IMAGE_WIDTH  = 2'd0,
        CFG_IMAGE_HEIGHT = 2'd1,
        CFG_MAX_GRAY     = 2'd2
    } t_cfg_index;

    typedef struct packed {
        logic                  wr_en;
        logic [COL_BITS-1:0]   wr_addr;
        logic [PIXEL_BITS-1:0] wr_data;
        logic                  rd_en;
        logic [COL_BITS-1:0]   rd_addr_here;
        logic [COL_BITS-1:0]   rd_addr_right;
    } t_ls_req;

    typedef struct packed {
        logic [PIXEL_BITS-1:0] here;
        logic [PIXEL_BITS-1:0] right;
    } t_ls_rsp;

    function automatic logic [PIXEL_BITS-1:0] absdiff(
        input logic [PIXEL_BITS-1:0] a,
        input logic [PIXEL_BITS-1:0] b
    );
        return (a > b) ? (a - b) : (b - a);
    endfunction

endpackage

### rtl/gcf_if.sv
// gcf_if: pixel, result and configuration channels of the gradient contour filter
// depends on gcf_pkg for field widths
interface gcf_pix_if;
    logic                           valid;
    logic                           ready;
    logic [gcf_pkg::PIXEL_BITS-1:0] pixel;

    modport source (output valid, output pixel, input ready);
    modport sink   (input valid, input pixel, output ready);
endinterface

interface gcf_res_if;
    logic                          valid;
    logic                          ready;
    logic [gcf_pkg::GRAY_BITS-1:0] edge_value;
    logic [gcf_pkg::ROW_BITS-1:0]  out_row;
    logic [gcf_pkg::COL_BITS-1:0]  out_column;
    logic                          last_of_item;
    logic                          last_of_frame;

    modport source (output valid, output edge_value, output out_row, output out_column,
                    output last_of_item, output last_of_frame, input ready);
    modport sink   (input valid, input edge_value, input out_row, input out_column,
                    input last_of_item, input last_of_frame, output ready);
endinterface

interface gcf_cfg_if;
    logic                              valid;
    logic                              ready;
    logic [gcf_pkg::CFG_IDX_BITS-1:0]  index;
    logic [gcf_pkg::CFG_DATA_BITS-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

### rtl/gradient_contour_filter_top.sv
// gradient_contour_filter_top: forward-difference gradient edge detector
// depends on gcf_pkg, the channel interfaces and gcf_line_store
//
// Pixels enter in raster order; each result is clamped to max_gray and tagged with its row
// and column. A pixel below the first row gives |below - here| + |right - here| for the pixel
// above it; on the last row each pixel but the row's first also gives |here - left| for its
// left neighbour, and the final pixel of the frame gives its own result, zero. A new pixel
// is taken only once the previous pixel's last result loads into the output register, as
// there is a single result channel. A result passes the item register, then the output
// register. The line store is a 512 x 16 memory with no clearing after reset; the user must
// write sizes only between frames, which the block itself does not enforce.
module gradient_contour_filter_top (
    input  logic      i_clk,
    input  logic      i_rst_n,
    gcf_pix_if.sink   i_pix,
    gcf_res_if.source o_res,
    gcf_cfg_if.sink   i_cfg
);

    logic [gcf_pkg::SIZE_BITS-1:0]  r_image_width;
    logic [gcf_pkg::SIZE_BITS-1:0]  r_image_height;
    logic [gcf_pkg::GRAY_BITS-1:0]  r_max_gray;

    logic [gcf_pkg::COL_BITS-1:0]   r_col;
    logic [gcf_pkg::ROW_BITS-1:0]   r_row;
    logic [gcf_pkg::PIXEL_BITS-1:0] r_prev;

    logic [2:0]                     r_s1_pend;
    logic [2:0]                     n_s1_pend;
    logic [gcf_pkg::PIXEL_BITS-1:0] r_s1_pixel;
    logic [gcf_pkg::PIXEL_BITS-1:0] r_s1_prev;
    logic [gcf_pkg::COL_BITS-1:0]   r_s1_col;
    logic [gcf_pkg::ROW_BITS-1:0]   r_s1_row;
    logic                           r_s1_last_col;

    logic                           r_out_valid;
    logic [gcf_pkg::GRAY_BITS-1:0]  r_out_value;
    logic [gcf_pkg::ROW_BITS-1:0]   r_out_row;
    logic [gcf_pkg::COL_BITS-1:0]   r_out_col;
    logic                           r_out_last_item;
    logic                           r_out_last_frame;

    logic [gcf_pkg::SIZE_BITS-1:0]  w_eff;
    logic [gcf_pkg::SIZE_BITS-1:0]  h_eff;
    logic                           last_col;
    logic                           last_row;
    logic                           in_fire;
    logic                           s1_busy;
    logic                           out_load;
    logic [2:0]                     sel;
    logic [2:0]                     rest;

    logic [gcf_pkg::PIXEL_BITS-1:0] right_eff;
    logic [gcf_pkg::GRAY_BITS:0]    sum_down;
    logic [gcf_pkg::GRAY_BITS-1:0]  val_above;
    logic [gcf_pkg::GRAY_BITS-1:0]  val_left;
    logic [gcf_pkg::GRAY_BITS-1:0]  val_frame;
    logic [gcf_pkg::GRAY_BITS-1:0]  n_out_value;
    logic [gcf_pkg::ROW_BITS-1:0]   n_out_row;
    logic [gcf_pkg::COL_BITS-1:0]   n_out_col;
    logic                           n_out_last_frame;

    gcf_pkg::t_ls_req               ls_req;
    gcf_pkg::t_ls_rsp               ls_rsp;

    // configuration registers
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_image_width  <= gcf_pkg::SIZE_BITS'(gcf_pkg::MAX_WIDTH);
            r_image_height <= gcf_pkg::SIZE_BITS'(gcf_pkg::ROW_LIMIT);
            r_max_gray     <= gcf_pkg::GRAY_BITS'(255);
        end else if (i_cfg.valid) begin
            unique case (gcf_pkg::t_cfg_index'(i_cfg.index))
                gcf_pkg::CFG_IMAGE_WIDTH:  r_image_width  <= i_cfg.data[gcf_pkg::SIZE_BITS-1:0];
                gcf_pkg::CFG_IMAGE_HEIGHT: r_image_height <= i_cfg.data[gcf_pkg::SIZE_BITS-1:0];
                gcf_pkg::CFG_MAX_GRAY:     r_max_gray     <= i_cfg.data[gcf_pkg::GRAY_BITS-1:0];
                default: ;
            endcase
        end
    end

    // effective frame size and position flags
    always_comb begin
        if (r_image_width == '0) begin
            w_eff = gcf_pkg::SIZE_BITS'(1);
        end else if (r_image_width > gcf_pkg::SIZE_BITS'(gcf_pkg::MAX_WIDTH)) begin
            w_eff = gcf_pkg::SIZE_BITS'(gcf_pkg::MAX_WIDTH);
        end else begin
            w_eff = r_image_width;
        end
        if (r_image_height == '0) begin
            h_eff = gcf_pkg::SIZE_BITS'(1);
        end else if (r_image_height > gcf_pkg::SIZE_BITS'(gcf_pkg::ROW_LIMIT)) begin
            h_eff = gcf_pkg::SIZE_BITS'(gcf_pkg::ROW_LIMIT);
        end else begin
            h_eff = r_image_height;
        end
    end

    assign last_col = gcf_pkg::SIZE_BITS'(r_col) >= (w_eff - gcf_pkg::SIZE_BITS'(1));
    assign last_row = gcf_pkg::SIZE_BITS'(r_row) >= (h_eff - gcf_pkg::SIZE_BITS'(1));

    // result slot scheduling
    assign s1_busy  = |r_s1_pend;
    assign out_load = s1_busy && (!r_out_valid || o_res.ready);
    assign sel      = r_s1_pend & (~r_s1_pend + 3'd1);
    assign rest     = r_s1_pend & ~sel;

    assign i_pix.ready = !s1_busy || (out_load && (rest == '0));
    assign in_fire     = i_pix.valid && i_pix.ready;

    always_comb begin
        n_s1_pend[0] = (r_row != '0);
        n_s1_pend[1] = last_row && (r_col != '0);
        n_s1_pend[2] = last_row && last_col;
    end

    // line store access
    always_comb begin
        ls_req.wr_en         = in_fire;
        ls_req.wr_addr       = r_col;
        ls_req.wr_data       = i_pix.pixel;
        ls_req.rd_en         = in_fire;
        ls_req.rd_addr_here  = r_col;
        ls_req.rd_addr_right = r_col + gcf_pkg::COL_BITS'(1);
    end

    gcf_line_store u_line_store (
        .i_clk (i_clk),
        .i_req (ls_req),
        .o_rsp (ls_rsp)
    );

    // raster position and previous pixel
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col  <= '0;
            r_row  <= '0;
            r_prev <= '0;
        end else if (in_fire) begin
            r_prev <= i_pix.pixel;
            if (last_col) begin
                r_col <= '0;
                r_row <= last_row ? '0 : r_row + gcf_pkg::ROW_BITS'(1);
            end else begin
                r_col <= r_col + gcf_pkg::COL_BITS'(1);
            end
        end
    end

    // item register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_pend <= '0;
        end else if (in_fire) begin
            r_s1_pend <= n_s1_pend;
        end else if (out_load) begin
            r_s1_pend <= rest;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_s1_pixel    <= i_pix.pixel;
            r_s1_prev     <= r_prev;
            r_s1_col      <= r_col;
            r_s1_row      <= r_row;
            r_s1_last_col <= last_col;
        end
    end

    // gradient arithmetic
    always_comb begin
        right_eff = r_s1_last_col ? ls_rsp.here : ls_rsp.right;
        sum_down  = {1'b0, gcf_pkg::absdiff(r_s1_pixel, ls_rsp.here)}
                  + {1'b0, gcf_pkg::absdiff(right_eff, ls_rsp.here)};
        val_above = (sum_down > {1'b0, r_max_gray}) ? r_max_gray
                                                     : sum_down[gcf_pkg::GRAY_BITS-1:0];
        val_left  = gcf_pkg::absdiff(r_s1_pixel, r_s1_prev);
        if (val_left > r_max_gray) begin
            val_left = r_max_gray;
        end
        val_frame = '0;
    end

    always_comb begin
        n_out_value      = '0;
        n_out_row        = r_s1_row;
        n_out_col        = r_s1_col;
        n_out_last_frame = 1'b0;
        if (sel[0]) begin
            n_out_value = val_above;
            n_out_row   = r_s1_row - gcf_pkg::ROW_BITS'(1);
        end else if (sel[1]) begin
            n_out_value = val_left;
            n_out_col   = r_s1_col - gcf_pkg::COL_BITS'(1);
        end else if (sel[2]) begin
            n_out_value      = val_frame;
            n_out_last_frame = 1'b1;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= 1'b1;
        end else if (o_res.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out_value      <= n_out_value;
            r_out_row        <= n_out_row;
            r_out_col        <= n_out_col;
            r_out_last_item  <= (rest == '0);
            r_out_last_frame <= n_out_last_frame;
        end
    end

    assign o_res.valid         = r_out_valid;
    assign o_res.edge_value    = r_out_value;
    assign o_res.out_row       = r_out_row;
    assign o_res.out_column    = r_out_col;
    assign o_res.last_of_item  = r_out_last_item;
    assign o_res.last_of_frame = r_out_last_frame;

endmodule

### rtl/gcf_line_store.sv
// gcf_line_store: one image row of pixels, one write port and two registered read ports
// depends on gcf_pkg for t_ls_req and t_ls_rsp
module gcf_line_store (
    input  logic             i_clk,
    input  gcf_pkg::t_ls_req i_req,
    output gcf_pkg::t_ls_rsp o_rsp
);

    logic [gcf_pkg::PIXEL_BITS-1:0] mem [gcf_pkg::MAX_WIDTH];
    gcf_pkg::t_ls_rsp               r_rsp;

    // read before write: a read at the written address returns the old row
    always_ff @(posedge i_clk) begin
        if (i_req.wr_en) begin
            mem[i_req.wr_addr] <= i_req.wr_data;
        end
        if (i_req.rd_en) begin
            r_rsp.here  <= mem[i_req.rd_addr_here];
            r_rsp.right <= mem[i_req.rd_addr_right];
        end
    end

    assign o_rsp = r_rsp;

endmodule

### rtl/gcf_checker.sv
// gcf_checker: port-level checks on the result channel of the gradient contour filter
// depends on gcf_pkg; bound to gradient_contour_filter_top below
module gcf_checker (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          i_res_valid,
    input logic                          i_res_ready,
    input logic [gcf_pkg::GRAY_BITS-1:0] i_edge_value,
    input logic [gcf_pkg::ROW_BITS-1:0]  i_out_row,
    input logic [gcf_pkg::COL_BITS-1:0]  i_out_column,
    input logic                          i_last_of_item,
    input logic                          i_last_of_frame
);

    // stalled result beat holds
    a_res_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid && !i_res_ready |=> i_res_valid && $stable(i_edge_value)
            && $stable(i_out_row) && $stable(i_out_column)
            && $stable(i_last_of_item) && $stable(i_last_of_frame))
        else $error("result beat changed while stalled");

    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_res_valid)
        else $error("result valid after reset");

    // frame end closes its pixel's burst
    a_frame_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid && i_last_of_frame |-> i_last_of_item)
        else $error("frame end without item end");

    // nothing lies beyond the final pixel
    a_frame_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid && i_last_of_frame |-> i_edge_value == '0)
        else $error("frame end result not zero");

endmodule

bind gradient_contour_filter_top gcf_checker u_gcf_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_res_valid     (o_res.valid),
    .i_res_ready     (o_res.ready),
    .i_edge_value    (o_res.edge_value),
    .i_out_row       (o_res.out_row),
    .i_out_column    (o_res.out_column),
    .i_last_of_item  (o_res.last_of_item),
    .i_last_of_frame (o_res.last_of_frame)
);

### tb/gradient_contour_filter_top_tb.sv
// gradient_contour_filter_top_tb: self-checking bench for the gradient contour filter
// drives whole frames of pixels under random idling and checks every result beat against
// its own copy of the filter's state; depends on gcf_pkg, the channel interfaces and the rtl
`timescale 1ns / 100ps

module gradient_contour_filter_top_tb;

    import gcf_pkg::*;

    localparam int CLK_PERIOD      = 12;
    localparam int SETTLE_CYCLES   = 6;
    localparam int DRAIN_CYCLES    = 10;
    localparam int QUIET_LIMIT     = 2000;
    localparam int HOLD_OFF_CYCLES = 300;
    localparam int RANDOM_PIXELS   = 130;
    localparam int TALL_ROWS       = 40;
    localparam int WIDE_COLUMNS    = 120;

    localparam logic [CFG_IDX_BITS-1:0] CFG_SPARE = 2'd3;

    typedef struct {
        logic [GRAY_BITS-1:0] edge_value;
        logic [ROW_BITS-1:0]  row;
        logic [COL_BITS-1:0]  column;
        logic                 last_item;
        logic                 last_frame;
    } t_edge_result;

    typedef logic [PIXEL_BITS-1:0] t_grey_seq [$];

    logic i_clk = 1'b0;
    logic i_rst_n;

    gcf_pix_if pix_ch ();
    gcf_res_if res_ch ();
    gcf_cfg_if cfg_ch ();

    gradient_contour_filter_top i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_pix   (pix_ch),
        .o_res   (res_ch),
        .i_cfg   (cfg_ch)
    );

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    // filter state as the bench sees it
    logic [PIXEL_BITS-1:0] line_copy [MAX_WIDTH];
    logic [PIXEL_BITS-1:0] prev_grey   = '0;
    int unsigned           row_pos     = 0;
    int unsigned           column_pos  = 0;
    logic [SIZE_BITS-1:0]  frame_width  = 10'd512;
    logic [SIZE_BITS-1:0]  frame_height = 10'd512;
    logic [GRAY_BITS-1:0]  gray_limit   = 16'd255;

    t_edge_result edge_q [$];
    int unsigned  error_count   = 0;
    int unsigned  pixels_sent   = 0;
    int unsigned  sink_hold_off = 0;
    bit           burst_mode    = 1'b0;

    function automatic int unsigned idle_cycles();
        return burst_mode ? 0 : $urandom_range(0, 7);
    endfunction

    function automatic int unsigned grey_distance(input int unsigned a, input int unsigned b);
        return (a > b) ? a - b : b - a;
    endfunction

    function automatic t_edge_result make_result(input int unsigned sum, input int unsigned row,
                                                 input int unsigned column, input logic frame_end);
        t_edge_result r;
        r.edge_value = (sum > 32'(gray_limit)) ? gray_limit : sum[GRAY_BITS-1:0];
        r.row        = row[ROW_BITS-1:0];
        r.column     = column[COL_BITS-1:0];
        r.last_item  = 1'b0;
        r.last_frame = frame_end;
        return r;
    endfunction

    function automatic logic [PIXEL_BITS-1:0] random_grey();
        case ($urandom_range(0, 7))
            0: return '0;
            1: return '1;
            default: return PIXEL_BITS'($urandom);
        endcase
    endfunction

    function automatic logic [CFG_DATA_BITS-1:0] size_data(input int unsigned n);
        return CFG_DATA_BITS'(($urandom & 32'hFC00) | (n & 32'h03FF));
    endfunction

    task automatic predict_gradient(input logic [PIXEL_BITS-1:0] p);
        t_edge_result batch [$];
        int unsigned  w, h, col, row, here, right;
        bit           last_col, last_row;
        w = 32'(frame_width);
        if (w < 1) w = 1;
        if (w > MAX_WIDTH) w = MAX_WIDTH;
        h = 32'(frame_height);
        if (h < 1) h = 1;
        if (h > ROW_LIMIT) h = ROW_LIMIT;
        col = column_pos;
        if (col >= MAX_WIDTH) col = MAX_WIDTH - 1;
        row = row_pos;
        last_col = (col >= w - 1);
        last_row = (row >= h - 1);
        // pixel above, then left neighbour on the last row, then the frame's own final pixel
        if (row > 0) begin
            here  = 32'(line_copy[col]);
            right = last_col ? here : 32'(line_copy[col + 1]);
            batch.push_back(make_result(grey_distance(32'(p), here) + grey_distance(right, here),
                                        row - 1, col, 1'b0));
        end
        if (last_row && col > 0)
            batch.push_back(make_result(grey_distance(32'(p), 32'(prev_grey)), row, col - 1,
                                        1'b0));
        if (last_row && last_col)
            batch.push_back(make_result(0, row, col, 1'b1));
        line_copy[col] = p;
        prev_grey      = p;
        if (last_col) begin
            column_pos = 0;
            row_pos    = last_row ? 0 : row + 1;
        end else begin
            column_pos = col + 1;
        end
        if (batch.size() != 0)
            batch[batch.size() - 1].last_item = 1'b1;
        foreach (batch[k])
            edge_q.push_back(batch[k]);
    endtask

    task automatic report_mismatch(input string field, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("%0t mismatch on %s: got %0d, expected %0d", $realtime, field, got, want);
        error_count++;
    endtask

    task automatic check_edge_beat();
        t_edge_result want;
        if (edge_q.size() == 0) begin
            report_mismatch("unexpected beat", 32'(res_ch.edge_value), 32'd0);
            return;
        end
        want = edge_q.pop_front();
        if (res_ch.edge_value !== want.edge_value)
            report_mismatch("edge_value", 32'(res_ch.edge_value), 32'(want.edge_value));
        if (res_ch.out_row !== want.row)
            report_mismatch("out_row", 32'(res_ch.out_row), 32'(want.row));
        if (res_ch.out_column !== want.column)
            report_mismatch("out_column", 32'(res_ch.out_column), 32'(want.column));
        if (res_ch.last_of_item !== want.last_item)
            report_mismatch("last_of_item", 32'(res_ch.last_of_item), 32'(want.last_item));
        if (res_ch.last_of_frame !== want.last_frame)
            report_mismatch("last_of_frame", 32'(res_ch.last_of_frame), 32'(want.last_frame));
    endtask

    task automatic wait_until_drained();
        while (edge_q.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_register(input logic [CFG_IDX_BITS-1:0] idx,
                                  input logic [CFG_DATA_BITS-1:0] data);
        wait_until_drained();
        @(negedge i_clk);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= data;
        do @(posedge i_clk); while (!(cfg_ch.valid && cfg_ch.ready));
        case (idx)
            CFG_IMAGE_WIDTH:  frame_width  = data[SIZE_BITS-1:0];
            CFG_IMAGE_HEIGHT: frame_height = data[SIZE_BITS-1:0];
            CFG_MAX_GRAY:     gray_limit   = data[GRAY_BITS-1:0];
            default: ;
        endcase
        @(negedge i_clk);
        cfg_ch.valid <= 1'b0;
    endtask

    task automatic configure_frame(input logic [CFG_DATA_BITS-1:0] width_data,
                                   input logic [CFG_DATA_BITS-1:0] height_data,
                                   input logic [CFG_DATA_BITS-1:0] gray);
        write_register(CFG_IMAGE_WIDTH, width_data);
        write_register(CFG_IMAGE_HEIGHT, height_data);
        write_register(CFG_MAX_GRAY, gray);
    endtask

    task automatic send_pixel(input logic [PIXEL_BITS-1:0] p);
        int unsigned gap;
        gap = idle_cycles();
        @(negedge i_clk);
        if (gap != 0) begin
            pix_ch.valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        pix_ch.valid <= 1'b1;
        pix_ch.pixel <= p;
        do @(posedge i_clk); while (!(pix_ch.valid && pix_ch.ready));
        predict_gradient(p);
        pixels_sent++;
    endtask

    task automatic run_frame(input t_grey_seq seq);
        foreach (seq[k])
            send_pixel(seq[k]);
        @(negedge i_clk);
        pix_ch.valid <= 1'b0;
    endtask

    task automatic run_random_frame(input int unsigned cols, input int unsigned rows);
        t_grey_seq seq;
        repeat (cols * rows)
            seq.push_back(random_grey());
        run_frame(seq);
    endtask

    task automatic test_extreme_pixels();
        configure_frame(16'hFC03, 16'hFC02, 16'hFFFF);
        run_frame('{16'h0000, 16'hFFFF, 16'h0000, 16'hFFFF, 16'h0000, 16'hFFFF});
    endtask

    task automatic test_clamping();
        configure_frame(16'd2, 16'd2, 16'd0);
        run_frame('{16'hFFFF, 16'h0000, 16'h0000, 16'hFFFF});
        write_register(CFG_MAX_GRAY, 16'd100);
        run_frame('{16'd0, 16'd200, 16'd50, 16'd0});
    endtask

    task automatic test_single_pixel_frames();
        // zero sizes behave as one
        configure_frame(16'd0, 16'd0, 16'h8000);
        run_frame('{16'h1234});
        write_register(CFG_SPARE, 16'hFFFF);
        configure_frame(16'd1, 16'd1, 16'h7FFF);
        run_frame('{16'hFFFF});
        write_register(CFG_IMAGE_HEIGHT, 16'd3);
        run_frame('{16'h0000, 16'hFFFF, 16'h0001});
    endtask

    task automatic test_tallest_frame();
        configure_frame(16'd1, CFG_DATA_BITS'(TALL_ROWS), 16'hFFFF);
        run_random_frame(1, TALL_ROWS);
    endtask

    task automatic test_widest_frame();
        configure_frame(CFG_DATA_BITS'(WIDE_COLUMNS), 16'd1, 16'hFFFF);
        run_random_frame(WIDE_COLUMNS, 1);
    endtask

    task automatic test_output_backpressure();
        configure_frame(16'd16, 16'd6, 16'hFFFF);
        burst_mode    = 1'b1;
        sink_hold_off = HOLD_OFF_CYCLES;
        run_random_frame(16, 6);
        burst_mode    = 1'b0;
    endtask

    task automatic test_random_frames();
        int unsigned          cols, rows, start;
        logic [GRAY_BITS-1:0] gray;
        start = pixels_sent;
        while (pixels_sent - start < RANDOM_PIXELS) begin
            cols = ($urandom_range(0, 7) == 0) ? $urandom_range(9, 40) : $urandom_range(1, 8);
            rows = ($urandom_range(0, 7) == 0) ? $urandom_range(9, 12) : $urandom_range(1, 8);
            case ($urandom_range(0, 3))
                0: gray = 16'hFFFF;
                1: gray = GRAY_BITS'($urandom_range(0, 255));
                default: gray = GRAY_BITS'($urandom);
            endcase
            configure_frame(size_data(cols), size_data(rows), gray);
            burst_mode = ($urandom_range(0, 3) == 0);
            run_random_frame(cols, rows);
            burst_mode = 1'b0;
        end
    endtask

    initial begin
        i_rst_n      = 1'b0;
        pix_ch.valid = 1'b0;
        pix_ch.pixel = '0;
        cfg_ch.valid = 1'b0;
        cfg_ch.index = CFG_IMAGE_WIDTH;
        cfg_ch.data  = '0;
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_extreme_pixels();
        test_clamping();
        test_single_pixel_frames();
        test_tallest_frame();
        test_widest_frame();
        test_output_backpressure();
        test_random_frames();

        while (edge_q.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (error_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

    // result side: random stalls, plus one long hold-off when asked
    initial begin : result_sink
        int unsigned stall;
        res_ch.ready = 1'b0;
        wait (i_rst_n === 1'b1);
        forever begin
            @(negedge i_clk);
            stall = idle_cycles();
            if (sink_hold_off != 0) begin
                stall         = sink_hold_off;
                sink_hold_off = 0;
            end
            if (stall != 0) begin
                res_ch.ready <= 1'b0;
                repeat (stall) @(negedge i_clk);
            end
            res_ch.ready <= 1'b1;
            do @(posedge i_clk); while (!(res_ch.valid && res_ch.ready));
            check_edge_beat();
        end
    end

    initial begin : watchdog
        int unsigned quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT) begin
            @(posedge i_clk);
            if ((pix_ch.valid && pix_ch.ready) || (res_ch.valid && res_ch.ready) ||
                (cfg_ch.valid && cfg_ch.ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("tb: failure");
        $finish;
    end

endmodule
